>>> design/hsv_to_rgb_led_drive_assert.svh
// Assertion macros shared by the HSV to RGB LED drive RTL.
`ifndef HSV_TO_RGB_LED_DRIVE_ASSERT_SVH
`define HSV_TO_RGB_LED_DRIVE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HSVLED_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsvled assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define HSVLED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsvled assertion failed");

`endif

>>> design/hsvled_pkg.sv
// Shared types and constants for the HSV to RGB LED drive.
`default_nettype none

package hsvled_pkg;

    localparam int HUE_W  = 9;
    localparam int CODE_W = 8;

    // Pipeline depth, input register through output register
    localparam int NUM_STAGES = 5;

    // hue / 60 as (hue * 1093) >> 16, exact for any 9-bit hue
    localparam logic [10:0] SECTOR_RECIP   = 11'd1093;
    localparam int          SECTOR_SHIFT   = 16;
    localparam logic [5:0]  DEG_PER_SECTOR = 6'd60;

    // 255 * 60; x / 15300 as (x * 4491470) >> 36, exact for x below 2^22
    localparam logic [13:0] Q_DENOM = 14'd15300;
    localparam logic [22:0] Q_RECIP = 23'd4491470;
    localparam int          Q_SHIFT = 36;

    typedef logic [HUE_W-1:0]  hue_t;
    typedef logic [CODE_W-1:0] code_t;

    typedef enum logic [3:0] {
        SEC_RED_YELLOW   = 4'd0,
        SEC_YELLOW_GREEN = 4'd1,
        SEC_GREEN_CYAN   = 4'd2,
        SEC_CYAN_BLUE    = 4'd3,
        SEC_BLUE_MAGENTA = 4'd4,
        SEC_MAGENTA_RED  = 4'd5
    } sector_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] vld;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

>>> design/hsvled_if.sv
// Valid/ready channel interfaces for HSV input and RGB duty output.
`default_nettype none

interface hsvled_in_if;
    import hsvled_pkg::*;

    logic  valid;
    logic  ready;
    hue_t  hue;
    code_t saturation;
    code_t brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsvled_out_if;
    import hsvled_pkg::*;

    logic  valid;
    logic  ready;
    code_t red_duty;
    code_t green_duty;
    code_t blue_duty;

    modport source (output valid, output red_duty, output green_duty, output blue_duty,
                    input ready);
    modport sink (input valid, input red_duty, input green_duty, input blue_duty,
                  output ready);
endinterface

`default_nettype wire

>>> design/hsv_to_rgb_led_drive.sv
// Top level: pipelined HSV to RGB conversion with optional inverted duties for anode-side LEDs.
`default_nettype none
`include "hsv_to_rgb_led_drive_assert.svh"

// Converts one HSV colour (hue 0..359 degrees, saturation and value as code/255)
// into three 8-bit PWM duty values using the six-sector table, with exact truncating
// integer arithmetic. The block is a five-stage pipeline and takes a new colour every
// clock unless output back-pressure has filled it. Stage 1 splits the hue into sector
// and remainder and forms v*(255-s), stage 2 divides that by 255 and forms the
// 15300-s*rem and 15300-s*(60-rem) numerators, stage 3 multiplies by v, stage 4
// divides by 15300 through a reciprocal multiply, and stage 5 routes by sector into
// the output register, where the duties are held until taken. Back-pressure on the
// output stalls the pipeline without loss; bubbles are squeezed out. When the
// inversion register is set every duty reads as 255 minus its value; it is applied in
// the last stage, so change it only while the pipeline is empty. A hue of 360 or above
// gives black.
module hsv_to_rgb_led_drive (
    input  wire logic     clk,
    input  wire logic     rst_n,
    hsvled_in_if.sink     hsv,
    hsvled_out_if.source  rgb,
    input  wire logic     cfg_we,
    input  wire logic     cfg_wdata
);
    import hsvled_pkg::*;

    pipe_ctrl_t ctrl;
    logic       anode_inv_reg;

    hsvled_pipe_ctrl u_pipe_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hsv.valid),
        .out_ready (rgb.ready),
        .ctrl      (ctrl)
    );

    assign hsv.ready = ctrl.en[0];
    assign rgb.valid = ctrl.vld[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anode_inv_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            anode_inv_reg <= cfg_wdata;
        end
    end

    // Stage 1: sector, remainder, v*(255-s)
    logic [19:0] hue_scaled;
    logic [9:0]  sector_deg;
    logic [9:0]  rem_full;
    code_t       sat_inv;
    logic [3:0]  s1_sector_reg, s1_sector_next;
    logic [5:0]  s1_rem_reg,    s1_rem_next;
    code_t       s1_sat_reg,    s1_sat_next;
    code_t       s1_v_reg,      s1_v_next;
    logic [15:0] s1_prodp_reg,  s1_prodp_next;

    assign hue_scaled     = 20'(hsv.hue) * 20'(SECTOR_RECIP);
    assign s1_sector_next = hue_scaled[SECTOR_SHIFT+3:SECTOR_SHIFT];
    // sector * 60 as sector * 64 - sector * 4
    assign sector_deg     = {s1_sector_next, 6'b0} - {4'b0, s1_sector_next, 2'b0};
    assign rem_full       = {1'b0, hsv.hue} - sector_deg;
    assign s1_rem_next    = rem_full[5:0];
    assign s1_sat_next    = hsv.saturation;
    assign s1_v_next      = hsv.brightness;
    // 255 - s, kept at 8 bits before widening
    assign sat_inv        = ~hsv.saturation;
    assign s1_prodp_next  = 16'(hsv.brightness) * 16'(sat_inv);

    // Stage 2: p = prod/255, numerators of q and t
    logic [16:0] div255_sum;
    logic [13:0] sat_rem;
    logic [13:0] sat_rem_c;
    logic [5:0]  rem_c;
    logic [3:0]  s2_sector_reg, s2_sector_next;
    code_t       s2_v_reg,      s2_v_next;
    code_t       s2_p_reg,      s2_p_next;
    logic [13:0] s2_numq_reg,   s2_numq_next;
    logic [13:0] s2_numt_reg,   s2_numt_next;

    // floor(x/255) as (x + x/256 + 1) / 256, exact up to 255*255
    assign div255_sum     = 17'(s1_prodp_reg) + 17'(s1_prodp_reg[15:8]) + 17'd1;
    assign rem_c          = DEG_PER_SECTOR - s1_rem_reg;
    assign sat_rem        = 14'(s1_sat_reg) * 14'(s1_rem_reg);
    assign sat_rem_c      = 14'(s1_sat_reg) * 14'(rem_c);
    assign s2_sector_next = s1_sector_reg;
    assign s2_v_next      = s1_v_reg;
    assign s2_p_next      = div255_sum[15:8];
    assign s2_numq_next   = Q_DENOM - sat_rem;
    assign s2_numt_next   = Q_DENOM - sat_rem_c;

    // Stage 3: v * numerator
    logic [3:0]  s3_sector_reg, s3_sector_next;
    code_t       s3_v_reg,      s3_v_next;
    code_t       s3_p_reg,      s3_p_next;
    logic [21:0] s3_prodq_reg,  s3_prodq_next;
    logic [21:0] s3_prodt_reg,  s3_prodt_next;

    assign s3_sector_next = s2_sector_reg;
    assign s3_v_next      = s2_v_reg;
    assign s3_p_next      = s2_p_reg;
    assign s3_prodq_next  = 22'(s2_v_reg) * 22'(s2_numq_reg);
    assign s3_prodt_next  = 22'(s2_v_reg) * 22'(s2_numt_reg);

    // Stage 4: divide by 15300 through the reciprocal
    logic [44:0] scaled_q;
    logic [44:0] scaled_t;
    logic [3:0]  s4_sector_reg, s4_sector_next;
    code_t       s4_v_reg,      s4_v_next;
    code_t       s4_p_reg,      s4_p_next;
    code_t       s4_q_reg,      s4_q_next;
    code_t       s4_t_reg,      s4_t_next;

    assign scaled_q       = 45'(s3_prodq_reg) * 45'(Q_RECIP);
    assign scaled_t       = 45'(s3_prodt_reg) * 45'(Q_RECIP);
    assign s4_sector_next = s3_sector_reg;
    assign s4_v_next      = s3_v_reg;
    assign s4_p_next      = s3_p_reg;
    assign s4_q_next      = scaled_q[Q_SHIFT+CODE_W-1:Q_SHIFT];
    assign s4_t_next      = scaled_t[Q_SHIFT+CODE_W-1:Q_SHIFT];

    // Stage 5: route by sector, invert for anode-side LEDs, output register
    code_t red_sel, green_sel, blue_sel;
    code_t red_reg,   red_next;
    code_t green_reg, green_next;
    code_t blue_reg,  blue_next;

    always_comb
    begin
        red_sel   = '0;
        green_sel = '0;
        blue_sel  = '0;
        unique case (sector_t'(s4_sector_reg))
            SEC_RED_YELLOW:
            begin
                red_sel = s4_v_reg; green_sel = s4_t_reg; blue_sel = s4_p_reg;
            end
            SEC_YELLOW_GREEN:
            begin
                red_sel = s4_q_reg; green_sel = s4_v_reg; blue_sel = s4_p_reg;
            end
            SEC_GREEN_CYAN:
            begin
                red_sel = s4_p_reg; green_sel = s4_v_reg; blue_sel = s4_t_reg;
            end
            SEC_CYAN_BLUE:
            begin
                red_sel = s4_p_reg; green_sel = s4_q_reg; blue_sel = s4_v_reg;
            end
            SEC_BLUE_MAGENTA:
            begin
                red_sel = s4_t_reg; green_sel = s4_p_reg; blue_sel = s4_v_reg;
            end
            SEC_MAGENTA_RED:
            begin
                red_sel = s4_v_reg; green_sel = s4_p_reg; blue_sel = s4_q_reg;
            end
            default:
            begin
                // hue beyond 359: black
                red_sel = '0; green_sel = '0; blue_sel = '0;
            end
        endcase
    end

    assign red_next   = anode_inv_reg ? ~red_sel   : red_sel;
    assign green_next = anode_inv_reg ? ~green_sel : green_sel;
    assign blue_next  = anode_inv_reg ? ~blue_sel  : blue_sel;

    always_ff @(posedge clk)
    begin
        if (ctrl.en[0])
        begin
            s1_sector_reg <= s1_sector_next;
            s1_rem_reg    <= s1_rem_next;
            s1_sat_reg    <= s1_sat_next;
            s1_v_reg      <= s1_v_next;
            s1_prodp_reg  <= s1_prodp_next;
        end
        if (ctrl.en[1])
        begin
            s2_sector_reg <= s2_sector_next;
            s2_v_reg      <= s2_v_next;
            s2_p_reg      <= s2_p_next;
            s2_numq_reg   <= s2_numq_next;
            s2_numt_reg   <= s2_numt_next;
        end
        if (ctrl.en[2])
        begin
            s3_sector_reg <= s3_sector_next;
            s3_v_reg      <= s3_v_next;
            s3_p_reg      <= s3_p_next;
            s3_prodq_reg  <= s3_prodq_next;
            s3_prodt_reg  <= s3_prodt_next;
        end
        if (ctrl.en[3])
        begin
            s4_sector_reg <= s4_sector_next;
            s4_v_reg      <= s4_v_next;
            s4_p_reg      <= s4_p_next;
            s4_q_reg      <= s4_q_next;
            s4_t_reg      <= s4_t_next;
        end
        if (ctrl.en[4])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.red_duty   = red_reg;
    assign rgb.green_duty = green_reg;
    assign rgb.blue_duty  = blue_reg;

    // Sector split stays within 0..8 with a remainder below 60
    `HSVLED_ASSERT_NOW(a_sector_range, clk, rst_n, ctrl.vld[0], s1_sector_reg <= 4'd8)
    `HSVLED_ASSERT_NOW(a_rem_range, clk, rst_n, ctrl.vld[0], s1_rem_reg < DEG_PER_SECTOR)
    // p never exceeds v, nor q and t after the divide
    `HSVLED_ASSERT_NOW(a_p_below_v, clk, rst_n, ctrl.vld[1], s2_p_reg <= s2_v_reg)
    `HSVLED_ASSERT_NOW(a_qt_below_v, clk, rst_n, ctrl.vld[3],
                       (s4_q_reg <= s4_v_reg) && (s4_t_reg <= s4_v_reg))

endmodule

`default_nettype wire

>>> design/hsvled_pipe_ctrl.sv
// Valid tracking and per-stage advance enables for the conversion pipeline.
`default_nettype none
`include "hsv_to_rgb_led_drive_assert.svh"

module hsvled_pipe_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               out_ready,
    output hsvled_pkg::pipe_ctrl_t  ctrl
);
    import hsvled_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] en;

    // A stage advances when empty or when the stage after it advances
    always_comb
    begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign ctrl.en  = en;
    assign ctrl.vld = vld_reg;

    // Input is held back only when every stage is full and the output is blocked
    `HSVLED_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !en[0],
                       (&vld_reg) && !out_ready)
    // A transfer in always lands in the first stage
    `HSVLED_ASSERT_NEXT(a_transfer_lands, clk, rst_n, in_valid && en[0], vld_reg[0])
    // A result taken at the output with nothing behind it leaves the output empty
    `HSVLED_ASSERT_NEXT(a_drain_clears, clk, rst_n,
                        out_ready && !vld_reg[NUM_STAGES-2], !vld_reg[NUM_STAGES-1])

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking bench for hsv_to_rgb_led_drive: directed and random colours against a predictor.
`timescale 1ns / 100ps

module tb;
    import hsvled_pkg::*;

    localparam int unsigned FULL_CODE    = 255;
    localparam int unsigned RANDOM_BATCH = 300;

    typedef struct packed {
        hue_t  hue;
        code_t sat;
        code_t val;
    } colour_t;

    typedef struct packed {
        code_t red;
        code_t green;
        code_t blue;
    } duty_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;

    hsvled_in_if  hsv_ch ();
    hsvled_out_if rgb_ch ();

    hsv_to_rgb_led_drive dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv       (hsv_ch),
        .rgb       (rgb_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    colour_t     colours_pending[$];
    duty_t       duty_expect[$];
    int unsigned colours_queued = 0;
    int unsigned colours_sent = 0;
    int unsigned mismatches = 0;
    bit          anode_mode = 1'b0;
    bit          hsv_taken = 1'b0;

    int unsigned in_gap = 0;
    int unsigned in_stretch = 0;
    bit          in_quiet = 1'b0;
    int unsigned out_stall = 0;
    int unsigned out_stretch = 0;
    bit          out_quiet = 1'b0;

    initial begin
        hsv_ch.valid = 1'b0;
        hsv_ch.hue = '0;
        hsv_ch.saturation = '0;
        hsv_ch.brightness = '0;
        rgb_ch.ready = 1'b0;
    end

    always #5 clk = ~clk;

    // Six-sector HSV to RGB with truncating integer divides
    function automatic duty_t convert_colour(colour_t c, bit anode);
        int unsigned rem;
        int unsigned v;
        int unsigned s;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        sector_t     sector;
        duty_t       d;
        v = c.val;
        s = c.sat;
        rem = c.hue % DEG_PER_SECTOR;
        sector = sector_t'(c.hue / DEG_PER_SECTOR);
        p = (v * (FULL_CODE - s)) / FULL_CODE;
        q = (v * (Q_DENOM - s * rem)) / Q_DENOM;
        t = (v * (Q_DENOM - s * (DEG_PER_SECTOR - rem))) / Q_DENOM;
        case (sector)
            SEC_RED_YELLOW:   begin r = v; g = t; b = p; end
            SEC_YELLOW_GREEN: begin r = q; g = v; b = p; end
            SEC_GREEN_CYAN:   begin r = p; g = v; b = t; end
            SEC_CYAN_BLUE:    begin r = p; g = q; b = v; end
            SEC_BLUE_MAGENTA: begin r = t; g = p; b = v; end
            SEC_MAGENTA_RED:  begin r = v; g = p; b = q; end
            default:          begin r = 0; g = 0; b = 0; end
        endcase
        if (anode)
        begin
            r = FULL_CODE - r;
            g = FULL_CODE - g;
            b = FULL_CODE - b;
        end
        d.red = code_t'(r);
        d.green = code_t'(g);
        d.blue = code_t'(b);
        return d;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int unsigned draw_gap(bit quiet);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic code_t rand_code();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 8'd0;
        else if (roll == 1)
            return 8'd255;
        else
            return code_t'($urandom_range(0, 255));
    endfunction

    function automatic colour_t rand_colour();
        colour_t c;
        if ($urandom_range(0, 7) == 0)
            // land on or next to a sector boundary
            c.hue = hue_t'((($urandom_range(0, 5) * 60) + 359 + $urandom_range(0, 2)) % 360);
        else
            c.hue = hue_t'($urandom_range(0, 359));
        c.sat = rand_code();
        c.val = rand_code();
        return c;
    endfunction

    task automatic queue_colour(colour_t c);
        colours_pending.push_back(c);
        colours_queued++;
    endtask

    task automatic queue_directed();
        queue_colour('{9'd0,   8'd255, 8'd255});
        queue_colour('{9'd59,  8'd255, 8'd255});
        queue_colour('{9'd60,  8'd255, 8'd255});
        queue_colour('{9'd119, 8'd128, 8'd200});
        queue_colour('{9'd120, 8'd255, 8'd255});
        queue_colour('{9'd179, 8'd255, 8'd255});
        queue_colour('{9'd180, 8'd1,   8'd254});
        queue_colour('{9'd239, 8'd255, 8'd255});
        queue_colour('{9'd240, 8'd255, 8'd255});
        queue_colour('{9'd299, 8'd77,  8'd255});
        queue_colour('{9'd300, 8'd255, 8'd255});
        queue_colour('{9'd359, 8'd255, 8'd255});
        // grey at zero saturation, black at zero brightness
        queue_colour('{9'd200, 8'd0,   8'd173});
        queue_colour('{9'd30,  8'd255, 8'd0});
    endtask

    task automatic write_anode(bit mode);
        @(negedge clk);
        cfg_wdata <= mode;
        cfg_we <= 1'b1;
        anode_mode = mode;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        wait (colours_sent == colours_queued && duty_expect.size() == 0);
        repeat (NUM_STAGES + 3) @(posedge clk);
    endtask

    // Source side: advance to the next colour once the current one has transferred
    always @(negedge clk)
    begin
        if (!hsv_ch.valid || hsv_taken)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                hsv_ch.valid <= 1'b0;
            end
            else if (colours_pending.size() > 0)
            begin
                colour_t c;
                c = colours_pending.pop_front();
                hsv_ch.hue <= c.hue;
                hsv_ch.saturation <= c.sat;
                hsv_ch.brightness <= c.val;
                hsv_ch.valid <= 1'b1;
                if (in_stretch == 0)
                begin
                    in_stretch = $urandom_range(10, 80);
                    in_quiet = ($urandom_range(0, 3) == 0);
                end
                in_stretch--;
                in_gap = draw_gap(in_quiet);
            end
            else
                hsv_ch.valid <= 1'b0;
        end
    end

    // Sink side: hold ready low for random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            rgb_ch.ready <= 1'b0;
        else if (out_stall > 0)
        begin
            out_stall--;
            rgb_ch.ready <= 1'b0;
        end
        else
        begin
            rgb_ch.ready <= 1'b1;
            if (out_stretch == 0)
            begin
                out_stretch = $urandom_range(10, 80);
                out_quiet = ($urandom_range(0, 3) == 0);
            end
            out_stretch--;
            out_stall = draw_gap(out_quiet);
        end
    end

    always @(posedge clk)
    begin
        hsv_taken <= rst_n && hsv_ch.valid && hsv_ch.ready;
        if (rst_n && hsv_ch.valid && hsv_ch.ready)
        begin
            duty_expect.push_back(convert_colour(
                '{hsv_ch.hue, hsv_ch.saturation, hsv_ch.brightness}, anode_mode));
            colours_sent++;
        end
        if (rst_n && rgb_ch.valid && rgb_ch.ready)
        begin
            if (duty_expect.size() == 0)
            begin
                $error("rgb transfer with no colour outstanding: r=%0d g=%0d b=%0d",
                       rgb_ch.red_duty, rgb_ch.green_duty, rgb_ch.blue_duty);
                mismatches++;
            end
            else
            begin
                duty_t d;
                d = duty_expect.pop_front();
                if (rgb_ch.red_duty !== d.red)
                begin
                    $error("red_duty: expected %0d, actual %0d", d.red, rgb_ch.red_duty);
                    mismatches++;
                end
                if (rgb_ch.green_duty !== d.green)
                begin
                    $error("green_duty: expected %0d, actual %0d", d.green, rgb_ch.green_duty);
                    mismatches++;
                end
                if (rgb_ch.blue_duty !== d.blue)
                begin
                    $error("blue_duty: expected %0d, actual %0d", d.blue, rgb_ch.blue_duty);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_anode(1'b0);
        queue_directed();
        drain();

        write_anode(1'b1);
        queue_directed();
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_anode(phase[0] ? 1'b1 : 1'b0);
            repeat (RANDOM_BATCH) queue_colour(rand_colour());
            drain();
        end

        if (mismatches == 0 && duty_expect.size() == 0)
            $display("hsv_to_rgb_led_drive: match");
        else
            $display("hsv_to_rgb_led_drive: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("hsv_to_rgb_led_drive: mismatch");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/hsvled_pkg.sv
design/hsvled_if.sv
design/hsvled_pipe_ctrl.sv
design/hsv_to_rgb_led_drive.sv
sim/tb.sv
